### rtl/rfc_pkg.sv
// shared types, constants and register map of the reciprocal frequency counter
package rfc_pkg;

    // field and register widths
    localparam int EDGE_PERIODS_W = 8;
    localparam int TIMEOUT_W      = 32;
    localparam int TICK_NS_W      = 16;
    localparam int FREQ_W         = 32;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 4;

    // time base width default for the tick counter
    localparam int DEF_TIME_WIDTH = 32;

    // numerator periods * 1e9 stays below 2^38
    localparam int NUM_W = 38;
    localparam logic [NUM_W-1:0] NS_PER_S = NUM_W'(64'd1000000000);

    // shift-add steps of the multiplier, one bit of tick_period_ns per cycle
    localparam int MUL_STEPS = TICK_NS_W;

    // register reset values
    localparam logic [EDGE_PERIODS_W-1:0] RST_EDGE_PERIODS = 8'd10;
    localparam logic [TIMEOUT_W-1:0]      RST_TIMEOUT      = 32'd1000000;
    localparam logic [TICK_NS_W-1:0]      RST_TICK_NS      = 16'd1000;

    // saturation value of the edge counter
    localparam logic [EDGE_PERIODS_W-1:0] EDGE_SAT = '1;

    // register indexes on the configuration port
    localparam logic [1:0] REG_EDGE_PERIODS = 2'd0;
    localparam logic [1:0] REG_TIMEOUT      = 2'd1;
    localparam logic [1:0] REG_TICK_NS      = 2'd2;

    // operation codes of an input word
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // status codes of a result word
    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_TIMEOUT = 1'b1;

    // measurement control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ARMED,
        ST_CALC
    } t_state;

    // arithmetic unit states
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_DIV,
        DV_DONE
    } t_div_state;

    // control from the measurement logic to the arithmetic unit
    typedef struct packed {
        logic start;
        logic ack;
    } t_div_ctl;

endpackage

### rtl/rfc_divider.sv
// bit-serial multiplier and restoring divider for the frequency quotient
module rfc_divider
    import rfc_pkg::*;
#(
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_div_ctl                  i_ctl,
    input  logic [TIME_WIDTH-1:0]     i_elapsed,
    input  logic [TICK_NS_W-1:0]      i_tick_ns,
    input  logic [EDGE_PERIODS_W-1:0] i_periods,
    output logic                      o_done,
    output logic [FREQ_W-1:0]         o_quot
);

    localparam int DEN_W = TIME_WIDTH + TICK_NS_W;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

    t_div_state r_state, n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [TIME_WIDTH-1:0] r_elapsed;
    logic [TICK_NS_W-1:0]  r_tick_sh;
    logic [MUL_STEPS-1:0]  r_per_sh;
    logic [DEN_W-1:0]      r_den;
    logic [DEN_W-1:0]      r_rem;
    logic [NUM_W-1:0]      r_num;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_fits;
    logic [DEN_W-1:0] w_den_add;
    logic [NUM_W-1:0] w_num_add;
    logic             w_mul_step;
    logic             w_div_step;

    // one partial product bit and one quotient bit per cycle
    assign w_den_add = r_tick_sh[TICK_NS_W-1] ? DEN_W'(r_elapsed) : '0;
    assign w_num_add = r_per_sh[MUL_STEPS-1] ? NS_PER_S : '0;
    assign w_trial   = {r_rem, r_num[NUM_W-1]};
    assign w_diff    = w_trial - {1'b0, r_den};
    assign w_fits    = (w_trial >= {1'b0, r_den});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE: if (i_ctl.start) n_state = DV_MUL;
            DV_MUL:  if (r_cnt == MUL_LAST) n_state = DV_DIV;
            DV_DIV:  if (r_cnt == DIV_LAST) n_state = DV_DONE;
            DV_DONE: if (i_ctl.ack) n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    // outputs and step strobes
    always_comb begin
        w_mul_step = 1'b0;
        w_div_step = 1'b0;
        o_done     = 1'b0;
        case (r_state)
            DV_MUL:  w_mul_step = 1'b1;
            DV_DIV:  w_div_step = 1'b1;
            DV_DONE: o_done     = 1'b1;
            default: o_done     = 1'b0;
        endcase
    end

    // zero divisor gives zero, quotient above 32 bits saturates
    always_comb begin
        if (r_den == '0) begin
            o_quot = '0;
        end else if (|r_num[NUM_W-1:FREQ_W]) begin
            o_quot = '1;
        end else begin
            o_quot = r_num[FREQ_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if ((w_mul_step && r_cnt == MUL_LAST) || (r_state == DV_IDLE)) begin
                r_cnt <= '0;
            end else if (w_mul_step || w_div_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        if (r_state == DV_IDLE && i_ctl.start) begin
            r_elapsed <= i_elapsed;
            r_tick_sh <= i_tick_ns;
            r_per_sh  <= MUL_STEPS'(i_periods);
            r_den     <= '0;
            r_num     <= '0;
            r_rem     <= '0;
        end else if (w_mul_step) begin
            r_den     <= {r_den[DEN_W-2:0], 1'b0} + w_den_add;
            r_num     <= {r_num[NUM_W-2:0], 1'b0} + w_num_add;
            r_tick_sh <= {r_tick_sh[TICK_NS_W-2:0], 1'b0};
            r_per_sh  <= {r_per_sh[MUL_STEPS-2:0], 1'b0};
        end else if (w_div_step) begin
            r_rem <= w_fits ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_fits};
        end
    end

endmodule

### rtl/reciprocal_frequency_counter.sv
// reciprocal frequency counter top level: tick counting, timeout, config port, result register
//
// A start word arms a measurement and clears the counters; each following tick word
// advances the tick counter, and its edge flag stamps a rising edge. The first edge
// stores its time, the edge that completes edge_periods periods ends the measurement
// with frequency_hz = edge_periods * 1e9 / (elapsed_ticks * tick_period_ns), truncated
// and saturated to 32 bits; passing timeout_ticks ends it with 0 and timeout status.
// Start and tick words are taken one per cycle while the input is not stalled, and a
// timeout result appears in the cycle after its tick. A completing edge hands the
// quotient to a bit-serial unit: shift-add multiplication (one bit of tick_period_ns
// per cycle) and restoring division (one quotient bit per cycle), and the input is
// stalled until the result is loaded into the output register. While a result word
// waits in the output register and the receiver stalls it, the input is stalled as
// well.
module reciprocal_frequency_counter
    import rfc_pkg::*;
#(
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_operation,
    input  logic              i_edge_req,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [FREQ_W-1:0] o_frequency_hz,
    output logic              o_status,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CMP_W = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    t_state r_state, n_state;

    logic [EDGE_PERIODS_W-1:0] r_edge_periods;
    logic [TIMEOUT_W-1:0]      r_timeout_ticks;
    logic [TICK_NS_W-1:0]      r_tick_period_ns;

    logic [EDGE_PERIODS_W-1:0] r_edges;
    logic [TIME_WIDTH-1:0]     r_ticks;
    logic [TIME_WIDTH-1:0]     r_first;

    logic              r_out_valid;
    logic [FREQ_W-1:0] r_freq;
    logic              r_status;

    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_start;
    logic                      w_tick;
    logic                      w_first;
    logic                      w_done_edge;
    logic                      w_timeout;
    logic [TIME_WIDTH-1:0]     w_ticks_inc;
    logic [EDGE_PERIODS_W-1:0] w_edges_inc;
    logic [TIME_WIDTH-1:0]     w_elapsed;
    logic                      w_load_div;
    logic                      w_cfg_wr;
    t_div_ctl                  w_div_ctl;
    logic                      w_div_done;
    logic [FREQ_W-1:0]         w_div_quot;

    // input handshake
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state == ST_CALC) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    // one step of the measurement per tick word
    always_comb begin
        w_ticks_inc = (r_ticks != TIME_MAX) ? r_ticks + TIME_WIDTH'(1) : r_ticks;
        w_edges_inc = (r_edges != EDGE_SAT) ? r_edges + EDGE_PERIODS_W'(1) : r_edges;
        w_elapsed   = w_ticks_inc - r_first;
        w_start     = w_accept && (i_operation == OP_START);
        w_tick      = w_accept && (i_operation == OP_TICK) && (r_state == ST_ARMED);
        w_first     = w_tick && i_edge_req && (r_edges == '0);
        w_done_edge = w_tick && i_edge_req && (r_edges != '0)
                      && (r_edges == r_edge_periods);
        w_timeout   = w_tick && !w_done_edge
                      && ((CMP_W'(w_ticks_inc) > CMP_W'(r_timeout_ticks))
                          || (w_ticks_inc == TIME_MAX));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) n_state = ST_ARMED;
            end
            ST_ARMED: begin
                if (w_start) begin
                    n_state = ST_ARMED;
                end else if (w_done_edge) begin
                    n_state = ST_CALC;
                end else if (w_timeout) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CALC: begin
                if (w_div_done && w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs to the arithmetic unit and result register
    always_comb begin
        w_div_ctl.start = 1'b0;
        w_div_ctl.ack   = 1'b0;
        w_load_div      = 1'b0;
        case (r_state)
            ST_ARMED: w_div_ctl.start = w_done_edge;
            ST_CALC: begin
                w_div_ctl.ack = w_div_done && w_out_free;
                w_load_div    = w_div_done && w_out_free;
            end
            default: w_div_ctl.start = 1'b0;
        endcase
    end

    // state and measurement counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_edges <= '0;
            r_ticks <= '0;
            r_first <= '0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_edges <= '0;
                r_ticks <= '0;
                r_first <= '0;
            end else if (w_tick) begin
                r_ticks <= w_ticks_inc;
                if (w_first) r_first <= w_ticks_inc;
                if (i_edge_req) r_edges <= w_edges_inc;
            end
        end
    end

    // quotient unit
    rfc_divider #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_div_ctl),
        .i_elapsed (w_elapsed),
        .i_tick_ns (r_tick_period_ns),
        .i_periods (r_edge_periods),
        .o_done    (w_div_done),
        .o_quot    (w_div_quot)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_out_valid && i_stall) || w_load_div || w_timeout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_div) begin
            r_freq   <= w_div_quot;
            r_status <= STAT_DONE;
        end else if (w_timeout) begin
            r_freq   <= '0;
            r_status <= STAT_TIMEOUT;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frequency_hz = r_freq;
    assign o_status       = r_status;

    // configuration registers
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_periods   <= RST_EDGE_PERIODS;
            r_timeout_ticks  <= RST_TIMEOUT;
            r_tick_period_ns <= RST_TICK_NS;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_EDGE_PERIODS: r_edge_periods   <= pwdata[EDGE_PERIODS_W-1:0];
                REG_TIMEOUT:      r_timeout_ticks  <= pwdata[TIMEOUT_W-1:0];
                REG_TICK_NS:      r_tick_period_ns <= pwdata[TICK_NS_W-1:0];
                default:          r_edge_periods   <= r_edge_periods;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_EDGE_PERIODS: prdata = DATA_W'(r_edge_periods);
            REG_TIMEOUT:      prdata = DATA_W'(r_timeout_ticks);
            REG_TICK_NS:      prdata = DATA_W'(r_tick_period_ns);
            default:          prdata = '0;
        endcase
    end

endmodule

### rtl/rfc_checker.sv
// port-level checks of the reciprocal frequency counter and their binding
module rfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_operation,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_frequency_hz,
    input logic        o_status
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_frequency_hz) && $stable(o_status))
        else $error("result payload changed while stalled");

    // a timed out measurement reports zero frequency
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_frequency_hz == 32'd0)
        else $error("timeout word with nonzero frequency");

    // reset leaves no result word behind
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result word present right after reset");

    // a start word never causes a result
    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(i_valid && !o_stall && i_operation))
        else $error("result word after a start word");

endmodule

bind reciprocal_frequency_counter rfc_checker u_rfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_operation    (i_operation),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_frequency_hz (o_frequency_hz),
    .o_status       (o_status)
);

### tb/sv/reciprocal_frequency_counter_check.sv
// checker of the reciprocal frequency counter: predicts and compares result words
module reciprocal_frequency_counter_check
    import rfc_pkg::*;
#(
    parameter int TIME_W = DEF_TIME_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              in_operation,
    input  logic              in_edge_req,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [FREQ_W-1:0] out_frequency_hz,
    input  logic              out_status,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FREQ_W-1:0] hz;
        logic              status;
    } t_freq_word;

    // register copies
    logic [EDGE_PERIODS_W-1:0] periods;
    logic [TIMEOUT_W-1:0]      timeout_limit;
    logic [TICK_NS_W-1:0]      tick_ns;

    // measurement state
    logic                      armed;
    logic [EDGE_PERIODS_W-1:0] edge_count;
    logic [TIME_W-1:0]         tick_count;
    logic [TIME_W-1:0]         first_stamp;

    t_freq_word expected_words[$];
    int         fails;

    // periods * 1e9 / (elapsed * tick_ns), truncated, saturated to the output width
    function automatic logic [FREQ_W-1:0] rate_hz(input logic [TIME_W-1:0] elapsed);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        num = 64'(periods) * 64'd1_000_000_000;
        den = 64'(elapsed) * 64'(tick_ns);
        if (den == 64'd0) return '0;
        quo = num / den;
        if (quo > 64'(32'hFFFF_FFFF)) return '1;
        return quo[FREQ_W-1:0];
    endfunction

    // one accepted input word: advance the measurement, queue a result if it ends
    task automatic measure_step(input logic op, input logic edg);
        t_freq_word w;
        if (op == OP_START) begin
            armed       = 1'b1;
            edge_count  = '0;
            tick_count  = '0;
            first_stamp = '0;
            return;
        end
        if (!armed) return;
        if (tick_count != '1) tick_count++;
        if (edg) begin
            if (edge_count == '0) begin
                first_stamp = tick_count;
            end else if (edge_count == periods) begin
                // completing edge wins over a timeout on the same tick
                w.hz     = rate_hz(tick_count - first_stamp);
                w.status = STAT_DONE;
                expected_words.push_back(w);
                armed = 1'b0;
                if (edge_count != EDGE_SAT) edge_count++;
                return;
            end
            if (edge_count != EDGE_SAT) edge_count++;
        end
        if (64'(tick_count) > 64'(timeout_limit) || tick_count == '1) begin
            w.hz     = '0;
            w.status = STAT_TIMEOUT;
            expected_words.push_back(w);
            armed = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            periods       = RST_EDGE_PERIODS;
            timeout_limit = RST_TIMEOUT;
            tick_ns       = RST_TICK_NS;
            armed         = 1'b0;
            edge_count    = '0;
            tick_count    = '0;
            first_stamp   = '0;
            fails         = 0;
            expected_words.delete();
        end else begin
            // register writes on the config port
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_EDGE_PERIODS: periods       = pwdata[EDGE_PERIODS_W-1:0];
                    REG_TIMEOUT:      timeout_limit = pwdata[TIMEOUT_W-1:0];
                    REG_TICK_NS:      tick_ns       = pwdata[TICK_NS_W-1:0];
                    default: ;
                endcase
            end
            // input word
            if (in_valid && !in_stall) measure_step(in_operation, in_edge_req);
            // result word against the oldest expectation
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    fails++;
                    $display("%0t unexpected result word: frequency_hz %0d status %0d",
                             $time, out_frequency_hz, out_status);
                end else begin
                    t_freq_word w;
                    w = expected_words.pop_front();
                    if (out_frequency_hz !== w.hz) begin
                        fails++;
                        $display("%0t frequency_hz mismatch: expected %0d, actual %0d",
                                 $time, w.hz, out_frequency_hz);
                    end
                    if (out_status !== w.status) begin
                        fails++;
                        $display("%0t status mismatch: expected %0d, actual %0d",
                                 $time, w.status, out_status);
                    end
                end
            end
        end
        fail_count <= fails;
        pending    <= expected_words.size();
    end

endmodule

### tb/sv/reciprocal_frequency_counter_test.sv
// testbench top of the reciprocal frequency counter: stimulus, register setup and verdict
module reciprocal_frequency_counter_test
    import rfc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT      = 400000;
    localparam int SETTLE_CYC = 100;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_stall;
    logic              i_operation    = OP_TICK;
    logic              i_edge_req     = 1'b0;
    logic              o_valid;
    logic              i_stall        = 1'b0;
    logic [FREQ_W-1:0] o_frequency_hz;
    logic              o_status;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [ADDR_W-1:0] paddr          = '0;
    logic [DATA_W-1:0] pwdata         = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int sent_words  = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    bit quiet_in    = 1'b0;
    bit quiet_out   = 1'b0;

    reciprocal_frequency_counter DUT (.*);

    reciprocal_frequency_counter_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .in_valid         (i_valid),
        .in_stall         (o_stall),
        .in_operation     (i_operation),
        .in_edge_req      (i_edge_req),
        .out_valid        (o_valid),
        .out_stall        (i_stall),
        .out_frequency_hz (o_frequency_hz),
        .out_status       (o_status),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("reciprocal_frequency_counter_test NOT OK");
            $finish;
        end
    end

    // offer one input word after a random gap, return once it is taken
    task automatic send_word(input logic op, input logic edg);
        int gap;
        if ($urandom_range(0, 15) == 0) quiet_in = !quiet_in;
        gap = quiet_in ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_edge_req  <= edg;
        do @(posedge i_clk); while (o_stall);
        sent_words++;
    endtask

    // wait until every expected word is back and the block has gone quiet
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // write all three registers back to back on the config port
    task automatic load_setup(input logic [EDGE_PERIODS_W-1:0] per,
                              input logic [TIMEOUT_W-1:0] tmo,
                              input logic [TICK_NS_W-1:0] tns);
        logic [DATA_W-1:0] vals[3];
        logic [1:0]        regs[3];
        vals = '{DATA_W'(per), DATA_W'(tmo), DATA_W'(tns)};
        regs = '{REG_EDGE_PERIODS, REG_TIMEOUT, REG_TICK_NS};
        for (int r = 0; r < 3; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {regs[r], 2'b00};
            pwdata  <= vals[r];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // start word followed by a run of ticks with random edge flags
    task automatic run_measurement(input int span, input int edge_pct);
        send_word(OP_START, 1'($urandom_range(0, 1)));
        repeat (span) send_word(OP_TICK, 1'($urandom_range(0, 99) < edge_pct));
    endtask

    // one register setting, mostly whole measurements, some stray words
    task automatic run_phase(input logic [EDGE_PERIODS_W-1:0] per,
                             input logic [TIMEOUT_W-1:0] tmo,
                             input logic [TICK_NS_W-1:0] tns,
                             input int edge_pct, input int span_lo, input int span_hi,
                             input int words);
        int first;
        settle();
        load_setup(per, tmo, tns);
        first = sent_words;
        while (sent_words - first < words) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_word(1'($urandom_range(0, 19) == 0), 1'($urandom_range(0, 1)));
            end else begin
                run_measurement($urandom_range(span_lo, span_hi), edge_pct);
            end
        end
    endtask

    task automatic random_phase(input int words);
        int per;
        int pct;
        per = $urandom_range(1, 8);
        pct = $urandom_range(20, 90);
        run_phase(EDGE_PERIODS_W'(per), TIMEOUT_W'($urandom_range(8, 120)),
                  TICK_NS_W'($urandom_range(1, 65535)), pct, 1,
                  (per + 2) * 150 / pct + 10, words);
    endtask

    // result side: random stalls that land on waiting words, plus one long hold-off
    initial begin : result_sink
        int gap;
        forever begin
            if ($urandom_range(0, 15) == 0) quiet_out = !quiet_out;
            gap = quiet_out ? 0 : $urandom_range(0, 17);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else if (gap > 0) begin
                i_stall <= 1'b1;
                do @(posedge i_clk); while (!o_valid);
                repeat (gap - 1) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick while idle is ignored
        send_word(OP_TICK, 1'b1);

        // one period on the fastest time base, edge flag on the start word ignored
        settle();
        load_setup(8'd1, 32'hFFFF_FFFF, 16'd1);
        send_word(OP_START, 1'b1);
        send_word(OP_TICK, 1'b1);
        send_word(OP_TICK, 1'b1);

        // restart while armed drops the old measurement
        send_word(OP_START, 1'b0);
        send_word(OP_TICK, 1'b1);
        send_word(OP_START, 1'b0);
        send_word(OP_TICK, 1'b0);
        send_word(OP_TICK, 1'b1);
        send_word(OP_TICK, 1'b1);

        // completing edge on the timeout tick wins
        settle();
        load_setup(8'd1, 32'd2, 16'd3);
        send_word(OP_START, 1'b0);
        send_word(OP_TICK, 1'b1);
        send_word(OP_TICK, 1'b0);
        send_word(OP_TICK, 1'b1);

        // zero periods never completes, ends by timeout
        settle();
        load_setup(8'd0, 32'd3, 16'hFFFF);
        send_word(OP_START, 1'b0);
        repeat (4) send_word(OP_TICK, 1'b1);

        // zero time base gives zero frequency, smallest timeout that still lets the period complete
        settle();
        load_setup(8'd1, 32'd1, 16'd0);
        send_word(OP_START, 1'b0);
        send_word(OP_TICK, 1'b1);
        send_word(OP_TICK, 1'b1);

        // random part: extremes first, then ordinary settings
        run_phase(8'd1, 32'hFFFF_FFFF, 16'hFFFF, 50, 1, 12, 100);
        run_phase(8'd255, 32'hFFFF_FFFF, 16'd1, 95, 250, 320, 250);
        // edge counter runs into saturation before the timeout
        run_phase(8'd0, 32'd300, TICK_NS_W'($urandom_range(1, 65535)), 100, 260, 320, 260);
        // long output hold-off with frequent results so the block backs up
        hold_cycles = 400;
        run_phase(8'd1, 32'd4, TICK_NS_W'($urandom_range(1, 65535)), 90, 1, 6, 150);
        run_phase(8'd3, 32'd60, 16'd0, 60, 1, 20, 80);
        repeat (3) random_phase(100);

        settle();
        if (fail_count == 0) begin
            $display("reciprocal_frequency_counter_test OK");
        end else begin
            $display("reciprocal_frequency_counter_test NOT OK");
        end
        $finish;
    end

endmodule

### files.f
rtl/rfc_pkg.sv
rtl/rfc_divider.sv
rtl/reciprocal_frequency_counter.sv
rtl/rfc_checker.sv
tb/sv/reciprocal_frequency_counter_check.sv
tb/sv/reciprocal_frequency_counter_test.sv
